// File: rtl/bucm_pkg.sv
// Shared constants, types and inferno color table for the bilinear upscale colormap unit.
`default_nettype none
package bucm_pkg;
   localparam int MAX_COLUMNS   = 1024;
   localparam int MAX_ROWS      = 1024;
   localparam int TABLE_ENTRIES = 256;
   localparam int SAMPLE_W      = 24;
   localparam int COLS_W        = 11;
   localparam int COORD_W       = 11;
   localparam int COLOR_W       = 8;
   localparam int CSR_IDX_W     = 2;
   localparam int ADDR_W        = $clog2(MAX_COLUMNS);
   localparam int ROW_W         = $clog2(MAX_ROWS);
   localparam int CNT_W         = (ADDR_W + 1 > COLS_W) ? ADDR_W + 1 : COLS_W;
   localparam int POS_W         = $clog2(TABLE_ENTRIES);
   localparam logic [COLS_W-1:0]   COLS_RESET  = COLS_W'(64);
   localparam logic [SAMPLE_W-1:0] SCALE_RESET = SAMPLE_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLUMNS    = 2'd0,
      CSR_LOW_TEMPERATURE = 2'd1,
      CSR_INDEX_SCALE     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic                last;
   } pix_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } color_type;

   typedef struct packed {
      logic                we;
      logic [ADDR_W-1:0]   waddr;
      logic [SAMPLE_W-1:0] wdata;
      logic                re;
      logic [ADDR_W-1:0]   raddr;
   } ram_cmd_type;

   localparam logic [COLOR_W-1:0] PALETTE [TABLE_ENTRIES][3] = '{
    '{0,0,4},'{1,0,5},'{1,1,6},'{1,1,8},'{2,1,10},'{2,2,12},'{2,2,14},'{3,2,16},
    '{4,3,18},'{4,3,20},'{5,4,23},'{6,4,25},'{7,5,27},'{8,5,29},'{9,6,32},'{10,6,34},
    '{11,7,36},'{12,7,39},'{13,8,41},'{14,8,43},'{16,9,46},'{17,9,48},'{18,10,51},
    '{20,10,53},
    '{21,11,56},'{22,11,58},'{24,12,61},'{25,12,63},'{27,12,66},'{28,13,68},'{30,13,71},
    '{31,13,73},
    '{33,13,76},'{35,14,78},'{36,14,81},'{38,14,83},'{40,14,86},'{41,14,88},'{43,14,91},
    '{45,14,93},
    '{47,14,95},'{48,14,98},'{50,14,100},'{52,14,102},'{54,14,105},'{56,14,107},
    '{57,14,109},'{59,14,111},
    '{61,13,113},'{63,13,115},'{65,13,117},'{67,13,119},'{69,13,121},'{70,13,123},
    '{72,13,125},'{74,12,127},
    '{76,12,128},'{78,12,130},'{80,12,132},'{82,11,133},'{84,11,135},'{86,11,136},
    '{88,10,138},'{90,10,139},
    '{92,10,140},'{94,10,142},'{96,9,143},'{98,9,144},'{100,9,145},'{102,9,146},
    '{104,9,147},'{106,8,148},
    '{108,8,149},'{110,8,150},'{112,8,151},'{114,8,152},'{116,8,152},'{118,8,153},
    '{120,8,154},'{122,8,154},
    '{124,8,155},'{126,8,155},'{128,8,156},'{130,8,156},'{132,8,156},'{134,9,157},
    '{136,9,157},'{138,9,157},
    '{140,10,157},'{142,10,157},'{144,10,157},'{146,11,157},'{148,11,157},'{150,12,157},
    '{152,12,157},'{154,13,157},
    '{156,14,157},'{158,14,156},'{160,15,156},'{162,16,156},'{164,17,155},'{166,17,155},
    '{168,18,154},'{170,19,154},
    '{172,20,153},'{174,21,152},'{176,22,152},'{178,23,151},'{180,24,150},'{182,25,149},
    '{184,27,148},'{186,28,147},
    '{188,29,146},'{190,30,145},'{192,32,144},'{193,33,143},'{195,35,142},'{197,36,141},
    '{199,38,139},'{200,39,138},
    '{202,41,137},'{204,43,135},'{206,44,134},'{207,46,133},'{209,48,131},'{210,50,130},
    '{212,52,128},'{214,54,127},
    '{215,56,125},'{217,58,124},'{218,60,122},'{220,62,121},'{221,64,119},'{223,66,117},
    '{224,68,116},'{226,71,114},
    '{227,73,112},'{228,75,111},'{230,77,109},'{231,79,107},'{232,82,105},'{234,84,104},
    '{235,86,102},'{236,89,100},
    '{237,91,98},'{238,93,97},'{239,96,95},'{240,98,93},'{241,100,91},'{242,103,89},
    '{243,105,88},'{244,108,86},
    '{245,110,84},'{246,113,82},'{246,115,80},'{247,118,79},'{248,120,77},'{249,123,75},
    '{249,125,73},'{250,128,71},
    '{250,130,70},'{251,133,68},'{252,135,66},'{252,138,64},'{253,141,62},'{253,143,60},
    '{254,146,59},'{254,148,57},
    '{254,151,55},'{255,153,53},'{255,156,51},'{255,159,50},'{255,161,48},'{255,164,46},
    '{255,166,45},'{255,169,43},
    '{255,172,41},'{255,174,40},'{255,177,38},'{255,180,37},'{255,182,35},'{255,185,34},
    '{255,188,32},'{255,190,31},
    '{255,193,30},'{255,196,29},'{255,199,27},'{255,201,26},'{255,204,25},'{255,207,24},
    '{255,210,24},'{255,212,23},
    '{255,215,22},'{255,218,22},'{255,221,21},'{255,223,21},'{255,226,21},'{255,229,21},
    '{255,231,21},'{255,234,21},
    '{255,237,22},'{255,239,22},'{255,242,23},'{255,244,24},'{255,247,25},'{254,249,27},
    '{254,252,28},'{252,254,30},
    '{251,255,31},'{249,255,33},'{248,255,35},'{246,255,37},'{244,255,39},'{243,255,41},
    '{241,255,43},'{239,255,46},
    '{238,255,48},'{236,255,50},'{234,255,53},'{232,255,55},'{231,255,58},'{229,255,60},
    '{227,255,63},'{225,255,66},
    '{223,255,68},'{222,255,71},'{220,255,74},'{218,255,77},'{216,255,80},'{214,255,83},
    '{212,255,86},'{210,255,89},
    '{208,255,92},'{206,255,95},'{204,255,98},'{202,255,101},'{200,255,104},'{198,255,107},
    '{196,255,111},'{194,255,114},
    '{192,255,117},'{190,255,120},'{188,255,124},'{186,255,127},'{184,255,130},'{182,255,134},
    '{180,255,137},'{178,255,141},
    '{175,255,144},'{173,255,148},'{171,255,151},'{169,255,155},'{167,255,159},'{165,255,162},
    '{163,255,166},'{252,255,164}
   };
endpackage
`default_nettype wire

// File: rtl/bucm_req_if.sv
// Input channel: one grid sample word.
`default_nettype none
interface bucm_req_if;
   import bucm_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] temperature;
   logic                last_of_frame;
   modport source (output valid, temperature, last_of_frame, input ready);
   modport sink   (input valid, temperature, last_of_frame, output ready);
endinterface
`default_nettype wire

// File: rtl/bucm_rsp_if.sv
// Result channel: one colored subpixel word.
`default_nettype none
interface bucm_rsp_if;
   import bucm_pkg::*;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   logic [COORD_W-1:0] sub_column;
   logic [COORD_W-1:0] sub_row;
   logic               last_of_run;
   modport source (output valid, red, green, blue, sub_column, sub_row, last_of_run,
                   input ready);
   modport sink   (input valid, red, green, blue, sub_column, sub_row, last_of_run,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/bucm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bucm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

// File: rtl/bucm_seq.sv
// Sample sequencer: counters, line store access and 2x2 subpixel generation.
`default_nettype none
module bucm_seq (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [bucm_pkg::COLS_W-1:0]     cols,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [bucm_pkg::SAMPLE_W-1:0]   temperature,
   input  wire logic                            last_of_frame,
   output logic                                 pix_valid,
   input  wire logic                            pix_ready,
   output bucm_pkg::pix_type                    pix,
   output bucm_pkg::ram_cmd_type                ram_cmd,
   input  wire logic [bucm_pkg::SAMPLE_W-1:0]   ram_rdata
);
   import bucm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_READ_A  = 5'b00010,
      S_READ_B  = 5'b00100,
      S_WRITE_C = 5'b01000,
      S_EMIT    = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [SAMPLE_W-1:0] t_ff, l_ff, a_ff, b_ff;
   logic [ADDR_W-1:0]   c_ff;
   logic [ROW_W-1:0]    r_ff;
   logic                end_ff;
   logic [1:0]          sub_ff, sub_in;

   logic [CNT_W-1:0]    cols_eff;
   logic [ADDR_W-1:0]   c_cur;
   logic                end_row;
   logic                accept;
   logic [SAMPLE_W:0]   sum_ab, sum_al;
   logic [SAMPLE_W+1:0] sum4;
   logic [ADDR_W-1:0]   cm1;
   logic [ROW_W-1:0]    rm1;

   always_comb begin
      if (CNT_W'(cols) < CNT_W'(2)) begin
         cols_eff = CNT_W'(2);
      end else if (CNT_W'(cols) > CNT_W'(MAX_COLUMNS)) begin
         cols_eff = CNT_W'(MAX_COLUMNS);
      end else begin
         cols_eff = CNT_W'(cols);
      end
      if (CNT_W'(col_ff) >= cols_eff) begin
         c_cur = ADDR_W'(cols_eff - CNT_W'(1));
      end else begin
         c_cur = col_ff;
      end
      end_row = (CNT_W'(c_cur) + CNT_W'(1)) >= cols_eff;
   end

   assign in_ready = (state_ff == S_IDLE);
   assign accept   = in_valid && in_ready;

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      prev_in  = prev_ff;
      sub_in   = sub_ff;
      ram_cmd  = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               prev_in       = temperature;
               sub_in        = 2'd0;
               ram_cmd.re    = 1'b1;
               ram_cmd.raddr = c_cur - ADDR_W'(1);
               if (last_of_frame) begin
                  col_in = '0;
                  row_in = '0;
               end else if (end_row) begin
                  col_in = '0;
                  row_in = (row_ff == ROW_W'(MAX_ROWS - 1)) ? '0 : row_ff + ROW_W'(1);
               end else begin
                  col_in = c_cur + ADDR_W'(1);
               end
               if (c_cur != '0) begin
                  state_in = S_READ_A;
               end else if (end_row) begin
                  state_in = S_WRITE_C;
               end
            end
         end
         S_READ_A: begin
            ram_cmd.re    = 1'b1;
            ram_cmd.raddr = c_ff;
            state_in      = S_READ_B;
         end
         S_READ_B: begin
            ram_cmd.we    = 1'b1;
            ram_cmd.waddr = c_ff - ADDR_W'(1);
            ram_cmd.wdata = l_ff;
            if (end_ff) begin
               state_in = S_WRITE_C;
            end else if (r_ff != '0) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WRITE_C: begin
            ram_cmd.we    = 1'b1;
            ram_cmd.waddr = c_ff;
            ram_cmd.wdata = t_ff;
            state_in = (r_ff != '0 && c_ff != '0) ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (pix_ready) begin
               sub_in = sub_ff + 2'd1;
               if (sub_ff == 2'd3) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      sum_ab    = {1'b0, a_ff} + {1'b0, b_ff};
      sum_al    = {1'b0, a_ff} + {1'b0, l_ff};
      sum4      = {2'b0, a_ff} + {2'b0, b_ff} + {2'b0, l_ff} + {2'b0, t_ff};
      cm1       = c_ff - ADDR_W'(1);
      rm1       = r_ff - ROW_W'(1);
      pix_valid = (state_ff == S_EMIT);
      case (sub_ff)
         2'd0:    pix.value = a_ff;
         2'd1:    pix.value = sum_ab[SAMPLE_W:1];
         2'd2:    pix.value = sum_al[SAMPLE_W:1];
         default: pix.value = sum4[SAMPLE_W+1:2];
      endcase
      pix.x    = COORD_W'({cm1, sub_ff[0]});
      pix.y    = COORD_W'({rm1, sub_ff[1]});
      pix.last = (sub_ff == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         prev_ff  <= '0;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         prev_ff  <= prev_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff   <= temperature;
         l_ff   <= prev_ff;
         c_ff   <= c_cur;
         r_ff   <= row_ff;
         end_ff <= end_row;
      end
      if (state_ff == S_READ_A) begin
         a_ff <= ram_rdata;
      end
      if (state_ff == S_READ_B) begin
         b_ff <= ram_rdata;
      end
   end
endmodule
`default_nettype wire

// File: rtl/bucm_color.sv
// Four-stage color pipeline: offset, split multiply, position and clamp, table blend.
`default_nettype none
module bucm_color (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [bucm_pkg::SAMPLE_W-1:0] low,
   input  wire logic [bucm_pkg::SAMPLE_W-1:0] scale,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire bucm_pkg::pix_type             pix,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output bucm_pkg::color_type                out
);
   import bucm_pkg::*;

   localparam int HALF_W = SAMPLE_W / 2;
   localparam int PP_W   = SAMPLE_W + HALF_W;
   localparam int PROD_W = 2 * SAMPLE_W;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } meta_type;

   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   meta_type            m1_ff, m2_ff, m3_ff;
   logic [SAMPLE_W-1:0] d1_ff;
   logic [PP_W-1:0]     plo2_ff, phi2_ff;
   logic [POS_W-1:0]    pos3_ff;
   logic [7:0]          f3_ff;
   color_type           out_ff;
   logic                en;
   logic [PROD_W-1:0]   prod;
   logic [POS_W-1:0]    pos_in;
   logic [7:0]          f_in;
   logic [COLOR_W-1:0]  blend [3];

   assign en       = !v4_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      prod = PROD_W'(plo2_ff) + (PROD_W'(phi2_ff) << HALF_W);
      if (prod[PROD_W-1:24] >= 24'(TABLE_ENTRIES - 1)) begin
         pos_in = POS_W'(TABLE_ENTRIES - 1);
         f_in   = '0;
      end else begin
         pos_in = prod[24 +: POS_W];
         f_in   = prod[23:16];
      end
   end

   always_comb begin
      logic [POS_W-1:0] nxt;
      logic [16:0]      acc;
      nxt = (pos3_ff == POS_W'(TABLE_ENTRIES - 1)) ? pos3_ff : pos3_ff + POS_W'(1);
      for (int ch = 0; ch < 3; ch++) begin
         acc = 17'(PALETTE[pos3_ff][ch]) * (17'd256 - 17'(f3_ff))
             + 17'(PALETTE[nxt][ch]) * 17'(f3_ff);
         blend[ch] = acc[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff   <= (pix.value > low) ? pix.value - low : '0;
         m1_ff   <= '{x: pix.x, y: pix.y, last: pix.last};
         plo2_ff <= PP_W'(d1_ff) * PP_W'(scale[HALF_W-1:0]);
         phi2_ff <= PP_W'(d1_ff) * PP_W'(scale[SAMPLE_W-1:HALF_W]);
         m2_ff   <= m1_ff;
         pos3_ff <= pos_in;
         f3_ff   <= f_in;
         m3_ff   <= m2_ff;
         out_ff  <= '{red: blend[0], green: blend[1], blue: blend[2],
                      x: m3_ff.x, y: m3_ff.y, last: m3_ff.last};
      end
   end

   assign out_valid = v4_ff;
   assign out       = out_ff;
endmodule
`default_nettype wire

// File: rtl/bilinear_upscale_colormap_unit.sv
// Top level: 2x bilinear upscaler with inferno color table blending.
// An accepted sample word passes S_READ_A and S_READ_B, plus S_WRITE_C at the last column of a
// row (extra line store write), before its four subpixel words are issued in S_EMIT.
// A new sample word is accepted only in S_IDLE, after those steps and any output stalls; row 0
// samples past column 0 skip S_EMIT; column 0 samples need S_IDLE alone. The steps are set by
// two reads and the writes on the line store's single read and write ports plus four pixel issues.
// Reset clears counters, previous sample and pipeline; the line store is not cleared.
`default_nettype none
module bilinear_upscale_colormap_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [bucm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bucm_pkg::SAMPLE_W-1:0]  csr_write_data,
   bucm_req_if.sink                            req,
   bucm_rsp_if.source                          rsp
);
   import bucm_pkg::*;

   logic [COLS_W-1:0]   cols_ff;
   logic [SAMPLE_W-1:0] low_ff;
   logic [SAMPLE_W-1:0] scale_ff;
   logic                pix_valid, pix_ready;
   pix_type             pix;
   ram_cmd_type         ram_cmd;
   logic [SAMPLE_W-1:0] ram_rdata;
   color_type           color;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= COLS_RESET;
         low_ff   <= '0;
         scale_ff <= SCALE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_COLUMNS:    cols_ff  <= csr_write_data[COLS_W-1:0];
            CSR_LOW_TEMPERATURE: low_ff   <= csr_write_data;
            CSR_INDEX_SCALE:     scale_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   bucm_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .cols          (cols_ff),
      .in_valid      (req.valid),
      .in_ready      (req.ready),
      .temperature   (req.temperature),
      .last_of_frame (req.last_of_frame),
      .pix_valid     (pix_valid),
      .pix_ready     (pix_ready),
      .pix           (pix),
      .ram_cmd       (ram_cmd),
      .ram_rdata     (ram_rdata)
   );

   bucm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_line (
      .clock (clock),
      .we    (ram_cmd.we),
      .waddr (ram_cmd.waddr),
      .wdata (ram_cmd.wdata),
      .re    (ram_cmd.re),
      .raddr (ram_cmd.raddr),
      .rdata (ram_rdata)
   );

   bucm_color u_color (
      .clock     (clock),
      .reset     (reset),
      .low       (low_ff),
      .scale     (scale_ff),
      .in_valid  (pix_valid),
      .in_ready  (pix_ready),
      .pix       (pix),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out       (color)
   );

   assign rsp.red         = color.red;
   assign rsp.green       = color.green;
   assign rsp.blue        = color.blue;
   assign rsp.sub_column  = color.x;
   assign rsp.sub_row     = color.y;
   assign rsp.last_of_run = color.last;

   a_rsp_held_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=>
         (rsp.valid && $stable(rsp.sub_column) && $stable(rsp.sub_row)))
      else $error("result word dropped or changed while stalled");

   a_store_idle_on_accept: assert property (@(posedge clock) disable iff (reset)
      ram_cmd.we |-> !(req.valid && req.ready))
      else $error("line store write overlaps sample accept");

   a_run_end_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last_of_run) |-> (rsp.sub_column[0] && rsp.sub_row[0]))
      else $error("run end word not at lower right subpixel");
endmodule
`default_nettype wire

// File: bench/testbench.sv
// Testbench for the 2x bilinear upscaler with inferno color blending: scoreboard and stimulus.
`default_nettype none
import bucm_pkg::*;

class upscale_scoreboard;
   int unsigned cols_reg  = 64;
   int unsigned low_temp  = 0;
   int unsigned scale_reg = 256;
   logic [SAMPLE_W-1:0] line_mem [MAX_COLUMNS];
   logic [SAMPLE_W-1:0] prev_sample = '0;
   int unsigned col_cnt = 0;
   int unsigned row_cnt = 0;
   color_type   pixel_q[$];
   int          fails = 0;
   int          checked = 0;

   function void configure(csr_index_type idx, logic [SAMPLE_W-1:0] data);
      case (idx)
         CSR_GRID_COLUMNS:    cols_reg  = data[COLS_W-1:0];
         CSR_LOW_TEMPERATURE: low_temp  = data;
         CSR_INDEX_SCALE:     scale_reg = data;
         default: ;
      endcase
   endfunction

   function color_type shade(int unsigned value, int unsigned x, int unsigned y, bit fin);
      color_type   px;
      logic [47:0] prod;
      int unsigned d, pos, frac, nxt, mix [3];
      d    = (value > low_temp) ? value - low_temp : 0;
      prod = 48'(d) * 48'(scale_reg);
      pos  = prod[31:24];
      frac = prod[23:16];
      if (prod >= (48'(TABLE_ENTRIES - 1) << 24)) begin
         pos  = TABLE_ENTRIES - 1;
         frac = 0;
      end
      nxt = (pos + 1 < TABLE_ENTRIES) ? pos + 1 : TABLE_ENTRIES - 1;
      for (int ch = 0; ch < 3; ch++)
         mix[ch] = (PALETTE[pos][ch] * (256 - frac) + PALETTE[nxt][ch] * frac) >> 8;
      px.red   = mix[0][7:0];
      px.green = mix[1][7:0];
      px.blue  = mix[2][7:0];
      px.x     = x[COORD_W-1:0];
      px.y     = y[COORD_W-1:0];
      px.last  = fin;
      return px;
   endfunction

   function void note_sample(logic [SAMPLE_W-1:0] t, logic fin);
      int unsigned cols, c, a, b, l, x, y;
      bit end_row;
      cols = cols_reg;
      if (cols < 2) cols = 2;
      if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
      c = (col_cnt >= cols) ? cols - 1 : col_cnt;
      if (row_cnt >= 1 && c >= 1) begin
         a = line_mem[c-1];
         b = line_mem[c];
         l = prev_sample;
         x = 2 * (c - 1);
         y = 2 * (row_cnt - 1);
         pixel_q.push_back(shade(a, x, y, 0));
         pixel_q.push_back(shade((a + b) >> 1, x + 1, y, 0));
         pixel_q.push_back(shade((a + l) >> 1, x, y + 1, 0));
         pixel_q.push_back(shade((a + b + l + t) >> 2, x + 1, y + 1, 1));
      end
      if (c >= 1) line_mem[c-1] = prev_sample;
      end_row = (c + 1 >= cols);
      if (end_row) line_mem[c] = t;
      prev_sample = t;
      if (fin) begin
         col_cnt = 0;
         row_cnt = 0;
      end else if (end_row) begin
         col_cnt = 0;
         row_cnt = (row_cnt + 1 >= MAX_ROWS) ? 0 : row_cnt + 1;
      end else begin
         col_cnt = c + 1;
      end
   endfunction

   function void check_pixel(color_type got);
      color_type exp_px;
      if (pixel_q.size() == 0) begin
         $error("unexpected result word x=%0d y=%0d", got.x, got.y);
         fails++;
         return;
      end
      exp_px = pixel_q.pop_front();
      checked++;
      if (got.red !== exp_px.red) begin
         $error("red: expected %0d, got %0d", exp_px.red, got.red); fails++;
      end
      if (got.green !== exp_px.green) begin
         $error("green: expected %0d, got %0d", exp_px.green, got.green); fails++;
      end
      if (got.blue !== exp_px.blue) begin
         $error("blue: expected %0d, got %0d", exp_px.blue, got.blue); fails++;
      end
      if (got.x !== exp_px.x) begin
         $error("sub_column: expected %0d, got %0d", exp_px.x, got.x); fails++;
      end
      if (got.y !== exp_px.y) begin
         $error("sub_row: expected %0d, got %0d", exp_px.y, got.y); fails++;
      end
      if (got.last !== exp_px.last) begin
         $error("last_of_run: expected %0d, got %0d", exp_px.last, got.last); fails++;
      end
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 800000;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SAMPLE_W-1:0]  csr_write_data = '0;
   int                   cycles = 0;
   int                   words_sent = 0;
   int                   burst_left = 0;
   int                   stall_mode = 0;
   upscale_scoreboard    sb = new();

   bucm_req_if req();
   bucm_rsp_if rsp();

   bilinear_upscale_colormap_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req.sink),
      .rsp              (rsp.source)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      req.valid = 0;
      req.temperature = '0;
      req.last_of_frame = 0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      color_type got;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         got.red   = rsp.red;
         got.green = rsp.green;
         got.blue  = rsp.blue;
         got.x     = rsp.sub_column;
         got.y     = rsp.sub_row;
         got.last  = rsp.last_of_run;
         sb.check_pixel(got);
      end
   end

   // receiver stall pattern: none, light or heavy, switching now and then
   always @(negedge clock) begin
      if ($urandom_range(0, 99) < 2) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp.ready <= 1;
         1: rsp.ready <= ($urandom_range(0, 3) != 0);
         default: rsp.ready <= ($urandom_range(0, 2) == 0);
      endcase
   end

   task automatic csr_write(csr_index_type idx, logic [SAMPLE_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = data;
      @(posedge clock);
      sb.configure(idx, data);
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   task automatic send_word(logic [SAMPLE_W-1:0] t, logic fin);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         repeat ($urandom_range(0, 5)) begin
            req.valid = 0;
            @(negedge clock);
         end
      end
      burst_left--;
      req.valid = 1;
      req.temperature = t;
      req.last_of_frame = fin;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_sample(t, fin);
      words_sent++;
   endtask

   // drain: stop sending, wait out expected words, then the block's own latency
   task automatic drain();
      @(negedge clock);
      req.valid = 0;
      wait (sb.pixel_q.size() == 0);
      repeat (24) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] rand_temp();
      int unsigned k;
      if ($urandom_range(0, 3) == 0) return SAMPLE_W'($urandom());
      k = $urandom_range(4, 24);
      return SAMPLE_W'(sb.low_temp + $urandom_range(0, (1 << k) - 1));
   endfunction

   task automatic send_frame(int unsigned cols, int unsigned rows, bit noise);
      int unsigned n;
      n = cols * rows;
      for (int unsigned i = 0; i < n; i++)
         send_word(rand_temp(), (i == n - 1) || (noise && $urandom_range(0, 99) < 3));
   endtask

   initial begin
      int unsigned cols, rows;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes of samples and registers, columns below the minimum
      csr_write(CSR_GRID_COLUMNS, 0);
      send_word(24'h000000, 0);
      send_word(24'hFFFFFF, 0);
      send_word(24'hFFFFFF, 0);
      send_word(24'h000000, 0);
      send_word(24'h00FFFF, 0);
      send_word(24'h7FFF00, 1);
      drain();
      csr_write(CSR_GRID_COLUMNS, 1);
      csr_write(CSR_LOW_TEMPERATURE, 24'hFFFFFF);
      csr_write(CSR_INDEX_SCALE, 24'hFFFFFF);
      send_word(24'hFFFFFF, 0);
      send_word(24'hFFFFFE, 0);
      send_word(24'h000001, 0);
      send_word(24'hFFFFFF, 1);
      drain();
      csr_write(CSR_LOW_TEMPERATURE, 24'h001000);
      csr_write(CSR_INDEX_SCALE, 24'h000000);
      csr_write(CSR_GRID_COLUMNS, 4);
      for (int i = 0; i < 7; i++) send_word(SAMPLE_W'(24'h001000 + i * 24'h40), 0);
      drain();
      // row shortened mid-frame: the count is already past the new end
      csr_write(CSR_GRID_COLUMNS, 3);
      csr_write(CSR_INDEX_SCALE, 24'h010000);
      send_word(24'h001080, 0);
      send_word(24'h0010C0, 0);
      send_word(24'h001100, 1);
      drain();

      // random frames with fresh settings each time
      while (words_sent < 190) begin
         cols = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
         rows = $urandom_range(1, 6);
         csr_write(CSR_GRID_COLUMNS, SAMPLE_W'(cols));
         csr_write(CSR_LOW_TEMPERATURE,
                   ($urandom_range(0, 3) == 0) ? '0 : SAMPLE_W'($urandom()));
         csr_write(CSR_INDEX_SCALE, ($urandom_range(0, 1) == 0) ?
                   SAMPLE_W'($urandom_range(0, 24'h3FFFF)) : SAMPLE_W'($urandom()));
         send_frame(cols, rows, 1);
         drain();
      end

      $display("%0d sample words sent, %0d result words checked, %0d mismatches",
               words_sent, sb.checked, sb.fails);
      $display("covered: columns below the minimum, extreme registers, shortened row, "
               , "random frames under output stalls");
      if (sb.fails == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
